[rtl/core/sce_pkg.sv]
// Package of the serial command line editor: sizes, codes, state types and prefix table.
`default_nettype none
package sce_pkg;

  localparam int unsigned LINE_DEPTH = 128;
  localparam int unsigned IDX_W      = $clog2(LINE_DEPTH);
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned NUM_WORDS  = 4;
  localparam int unsigned WORD_MAX   = 6;
  localparam int unsigned K_W        = $clog2(WORD_MAX);

  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TIL = 8'h7E;
  localparam logic [7:0] CH_DEL = 8'h7F;

  // Command words in match order: READ, HELP, CLEAR, STATUS.
  localparam logic [CHAR_W-1:0] WORD_TAB [NUM_WORDS][WORD_MAX] = '{
    '{7'h52, 7'h45, 7'h41, 7'h44, 7'h00, 7'h00},
    '{7'h48, 7'h45, 7'h4C, 7'h50, 7'h00, 7'h00},
    '{7'h43, 7'h4C, 7'h45, 7'h41, 7'h52, 7'h00},
    '{7'h53, 7'h54, 7'h41, 7'h54, 7'h55, 7'h53}
  };
  localparam logic [K_W:0] WORD_LEN [NUM_WORDS] = '{4'd4, 4'd4, 4'd5, 4'd6};

  typedef enum logic [2:0] {
    CMD_EMPTY   = 3'd0,
    CMD_READ    = 3'd1,
    CMD_HELP    = 3'd2,
    CMD_CLEAR   = 3'd3,
    CMD_STATUS  = 3'd4,
    CMD_UNKNOWN = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } top_state_e;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_SKIP,
    SC_MATCH
  } scan_state_e;

  typedef enum logic [1:0] {
    SEQ_SINGLE,
    SEQ_ERASE,
    SEQ_LINE
  } seq_e;

  typedef struct packed {
    logic             start;
    logic [IDX_W-1:0] end_pos;
  } scan_req_t;

  typedef struct packed {
    logic             done;
    cmd_e             code;
    logic [IDX_W-1:0] len;
  } scan_rsp_t;

endpackage
`default_nettype wire

[rtl/core/serial_command_line_editor.sv]
// Top level of the serial command line editor: input decode, line store, echo sequencing.
//
//  Channel | Dir | Handshake                         | Contents
//  s_axis  | in  | s_axis_tvalid_i / s_axis_tready_o | one received byte per word
//  m_axis  | out | m_axis_tvalid_o / m_axis_tready_i | one echo/result word, tlast ends a run
//
// Every accepted byte gives one run of one or three output words; the byte is decoded
// first and its words go out after. A line end adds a scan of the stored line over the
// single RAM read port: the scanner skips leading spaces, finds the first other
// character, compares up to six characters of command prefix and then reports. The
// input is not ready until the run is fully taken; a stalled output holds its word.
// Reset clears the line index, the top state and the scanner state; the line store
// itself needs no clearing.
`default_nettype none
module serial_command_line_editor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,   // [6:0] echo_char, [9:7] command_code,
                                             // [16:10] command_length, [23:17] zero
  output logic             m_axis_tlast_o,   // last_of_run
  output logic [2:0]       m_axis_tuser_o    // [0] echo_valid, [1] line_done, [2] typing
);
  import sce_pkg::*;

  top_state_e         st_q, st_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  seq_e               seq_q, seq_d;
  logic [1:0]         pos_q, pos_d;
  logic [CHAR_W-1:0]  ochar_q, ochar_d;
  logic               ovalid_q, ovalid_d;
  logic               olast_q, olast_d;
  logic               odone_q, odone_d;
  cmd_e               ocode_q, ocode_d;
  logic [IDX_W-1:0]   olen_q, olen_d;
  logic               otyp_q, otyp_d;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_raddr;
  logic [CHAR_W-1:0]  ram_rdata;
  scan_req_t          scan_req;
  scan_rsp_t          scan_rsp;

  logic [7:0]         c;
  logic               is_erase, is_eol, keep, full;

  // Byte classes: printable ASCII, CR, LF, BS and DEL are kept; anything else is dropped.
  assign c        = s_axis_tdata_i;
  assign is_erase = (c == CH_BS) || (c == CH_DEL);
  assign is_eol   = (c == CH_CR) || (c == CH_LF);
  assign keep     = is_erase || is_eol || ((c >= CH_SP) && (c <= CH_TIL));
  assign full     = idx_q >= IDX_W'(LINE_DEPTH - 1);

  sce_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (LINE_DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (c[CHAR_W-1:0]),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sce_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (scan_req),
    .rsp_o   (scan_rsp),
    .raddr_o (ram_raddr),
    .rdata_i (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      idx_q <= '0;
    end else begin
      st_q  <= st_d;
      idx_q <= idx_d;
    end
  end

  // Output word and run position; loaded before the output is ever shown valid.
  always_ff @(posedge clk_i) begin
    seq_q    <= seq_d;
    pos_q    <= pos_d;
    ochar_q  <= ochar_d;
    ovalid_q <= ovalid_d;
    olast_q  <= olast_d;
    odone_q  <= odone_d;
    ocode_q  <= ocode_d;
    olen_q   <= olen_d;
    otyp_q   <= otyp_d;
  end

  always_comb begin
    st_d             = st_q;
    idx_d            = idx_q;
    seq_d            = seq_q;
    pos_d            = pos_q;
    ochar_d          = ochar_q;
    ovalid_d         = ovalid_q;
    olast_d          = olast_q;
    odone_d          = odone_q;
    ocode_d          = ocode_q;
    olen_d           = olen_q;
    otyp_d           = otyp_q;
    ram_we           = 1'b0;
    scan_req.start   = 1'b0;
    scan_req.end_pos = idx_q;
    unique case (st_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          // Default run: a single word with no echo.
          seq_d    = SEQ_SINGLE;
          pos_d    = 2'd0;
          ochar_d  = '0;
          ovalid_d = 1'b0;
          olast_d  = 1'b1;
          odone_d  = 1'b0;
          ocode_d  = CMD_EMPTY;
          olen_d   = '0;
          otyp_d   = idx_q != '0;
          st_d     = ST_OUT;
          priority if (!keep) begin
            // Dropped byte: nothing changes.
          end else if (full) begin
            // A line that fills the store is thrown away along with this byte.
            idx_d  = '0;
            otyp_d = 1'b0;
          end else if (is_erase) begin
            if (idx_q != '0) begin
              idx_d    = idx_q - IDX_W'(1);
              otyp_d   = idx_q != IDX_W'(1);
              seq_d    = SEQ_ERASE;
              ochar_d  = CH_BS[CHAR_W-1:0];
              ovalid_d = 1'b1;
              olast_d  = 1'b0;
            end else begin
              otyp_d = 1'b0;
            end
          end else begin
            ram_we   = 1'b1;
            ochar_d  = c[CHAR_W-1:0];
            ovalid_d = 1'b1;
            if (is_eol) begin
              // The terminator is stored at idx_q and the scan stops just before it.
              idx_d          = '0;
              seq_d          = SEQ_LINE;
              olast_d        = 1'b0;
              odone_d        = 1'b1;
              otyp_d         = 1'b0;
              scan_req.start = 1'b1;
              st_d           = ST_SCAN;
            end else begin
              idx_d  = idx_q + IDX_W'(1);
              otyp_d = 1'b1;
            end
          end
        end
      end
      ST_SCAN: begin
        if (scan_rsp.done) begin
          ocode_d = scan_rsp.code;
          olen_d  = scan_rsp.len;
          st_d    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (m_axis_tready_i) begin
          if (olast_q) begin
            st_d = ST_IDLE;
          end else begin
            pos_d   = pos_q + 2'd1;
            olast_d = pos_q == 2'd1;
            unique case (seq_q)
              SEQ_ERASE: ochar_d = (pos_q == 2'd0) ? CH_SP[CHAR_W-1:0] : CH_BS[CHAR_W-1:0];
              SEQ_LINE:  ochar_d = (pos_q == 2'd0) ? CH_CR[CHAR_W-1:0] : CH_LF[CHAR_W-1:0];
              default:   ochar_d = ochar_q;
            endcase
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  assign s_axis_tready_o = st_q == ST_IDLE;
  assign m_axis_tvalid_o = st_q == ST_OUT;
  assign m_axis_tdata_o  = {7'd0, 7'(olen_q), 3'(ocode_q), ochar_q};
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tuser_o  = {otyp_q, odone_q, ovalid_q};

  // The block never takes a byte while a run is still being delivered.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input ready while a run is pending");

  // The scanner only answers while the editor waits for it.
  a_scan_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_rsp.done |-> (st_q == ST_SCAN))
    else $error("scan result outside of a scan");

  // A completed line always leaves an empty line behind.
  a_line_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |-> (idx_q == '0))
    else $error("line index not cleared at line end");

  // A taken word that is not the last of its run is followed by another word.
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=> m_axis_tvalid_o)
    else $error("run ended without a last word");

endmodule
`default_nettype wire

[rtl/core/sce_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sce_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

[rtl/core/sce_scan.sv]
// Line scanner: skips leading spaces and matches command prefixes one character per cycle.
`default_nettype none
module sce_scan (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire sce_pkg::scan_req_t        req_i,
  output sce_pkg::scan_rsp_t             rsp_o,
  output logic      [sce_pkg::IDX_W-1:0] raddr_o,
  input  wire logic [sce_pkg::CHAR_W-1:0] rdata_i
);
  import sce_pkg::*;

  scan_state_e            st_q, st_d;
  logic [IDX_W-1:0]       a_q, a_d;
  logic [IDX_W-1:0]       end_q, end_d;
  logic [IDX_W-1:0]       len_q, len_d;
  logic [K_W-1:0]         k_q, k_d;
  logic [NUM_WORDS-1:0]   flags_q, flags_d;
  logic [NUM_WORDS-1:0]   hit;
  scan_rsp_t              rsp_q, rsp_d;

  // Compare unit, one comparator per word: the current character against each word at this offset.
  always_comb begin
    for (int w = 0; w < NUM_WORDS; w++) begin
      hit[w] = ({1'b0, k_q} >= WORD_LEN[w]) || (rdata_i == WORD_TAB[w][k_q]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= SC_IDLE;
      rsp_q <= '0;
    end else begin
      st_q  <= st_d;
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    end_q   <= end_d;
    len_q   <= len_d;
    k_q     <= k_d;
    flags_q <= flags_d;
  end

  always_comb begin
    st_d       = st_q;
    a_d        = a_q;
    end_d      = end_q;
    len_d      = len_q;
    k_d        = k_q;
    flags_d    = flags_q;
    rsp_d      = rsp_q;
    rsp_d.done = 1'b0;
    unique case (st_q)
      SC_IDLE: begin
        if (req_i.start) begin
          a_d   = '0;
          end_d = req_i.end_pos;
          st_d  = SC_SKIP;
        end
      end
      SC_SKIP: begin
        if ((a_q < end_q) && (rdata_i == CH_SP[CHAR_W-1:0])) begin
          a_d = a_q + IDX_W'(1);
        end else begin
          len_d   = end_q - a_q;
          k_d     = '0;
          flags_d = '1;
          st_d    = SC_MATCH;
        end
      end
      SC_MATCH: begin
        if (IDX_W'(k_q) < len_q) begin
          flags_d = flags_q & hit;
        end
        if ((k_q == K_W'(WORD_MAX - 1)) || ((IDX_W'(k_q) + IDX_W'(1)) >= len_q)) begin
          rsp_d.done = 1'b1;
          rsp_d.len  = len_q;
          priority if (len_q == '0) begin
            rsp_d.code = CMD_EMPTY;
          end else if (flags_d[0] && (len_q >= IDX_W'(WORD_LEN[0]))) begin
            rsp_d.code = CMD_READ;
          end else if (flags_d[1] && (len_q >= IDX_W'(WORD_LEN[1]))) begin
            rsp_d.code = CMD_HELP;
          end else if (flags_d[2] && (len_q >= IDX_W'(WORD_LEN[2]))) begin
            rsp_d.code = CMD_CLEAR;
          end else if (flags_d[3] && (len_q >= IDX_W'(WORD_LEN[3]))) begin
            rsp_d.code = CMD_STATUS;
          end else begin
            rsp_d.code = CMD_UNKNOWN;
          end
          st_d = SC_IDLE;
        end else begin
          k_d = k_q + K_W'(1);
          a_d = a_q + IDX_W'(1);
        end
      end
      default: st_d = SC_IDLE;
    endcase
  end

  // The read port is addressed with the next address a_d, so rdata_i always holds the entry at a_q.
  assign raddr_o = a_d;
  assign rsp_o   = rsp_q;

endmodule
`default_nettype wire

[bench/serial_command_line_editor_checker.sv]
// Checker for the serial command line editor: predicts echo words and compares them.
`default_nettype none
module serial_command_line_editor_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  input  wire logic        s_axis_tready_i,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  wire logic        m_axis_tvalid_i,
  input  wire logic        m_axis_tready_i,
  input  wire logic [23:0] m_axis_tdata_i,   // [6:0] echo_char, [9:7] command_code,
                                             // [16:10] command_length, [23:17] zero
  input  wire logic        m_axis_tlast_i,   // last_of_run
  input  wire logic [2:0]  m_axis_tuser_i,   // [0] echo_valid, [1] line_done, [2] typing
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sce_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] echo_char;
    logic              echo_valid;
    logic              last_of_run;
    logic              line_done;
    cmd_e              code;
    logic [6:0]        length;
    logic              typing;
  } echo_word_t;

  logic [CHAR_W-1:0] line_q [LINE_DEPTH];
  int unsigned       fill;
  echo_word_t        expected_echo [$];
  int                fails;

  function automatic echo_word_t echo_word(logic [6:0] ch, logic vld, logic last, logic done,
                                           cmd_e code, logic [6:0] len, logic typ);
    echo_word_t w;
    w.echo_char   = ch;
    w.echo_valid  = vld;
    w.last_of_run = last;
    w.line_done   = done;
    w.code        = code;
    w.length      = len;
    w.typing      = typ;
    return w;
  endfunction

  function automatic bit begins_with(int first, int span, string w);
    int k;
    if (span < w.len()) return 1'b0;
    for (k = 0; k < w.len(); k++) begin
      if (line_q[first + k] != 7'(w[k])) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Case-sensitive prefix match, first hit wins in the order below.
  function automatic cmd_e classify(int first, int span);
    if (span == 0) return CMD_EMPTY;
    if (begins_with(first, span, "READ")) return CMD_READ;
    if (begins_with(first, span, "HELP")) return CMD_HELP;
    if (begins_with(first, span, "CLEAR")) return CMD_CLEAR;
    if (begins_with(first, span, "STATUS")) return CMD_STATUS;
    return CMD_UNKNOWN;
  endfunction

  task automatic take_byte(input logic [7:0] b);
    int   first;
    int   stop;
    int   span;
    cmd_e code;
    logic typ;
    if (!(b == CH_BS || b == CH_LF || b == CH_CR || b == CH_DEL ||
          (b >= CH_SP && b <= CH_TIL))) begin
      expected_echo.push_back(echo_word(7'd0, 1'b0, 1'b1, 1'b0, CMD_EMPTY, 7'd0, fill != 0));
    end else if (fill >= LINE_DEPTH - 1) begin
      // A full line is thrown away together with the byte that hit the limit.
      fill = 0;
      expected_echo.push_back(echo_word(7'd0, 1'b0, 1'b1, 1'b0, CMD_EMPTY, 7'd0, 1'b0));
    end else if (b == CH_BS || b == CH_DEL) begin
      if (fill == 0) begin
        expected_echo.push_back(echo_word(7'd0, 1'b0, 1'b1, 1'b0, CMD_EMPTY, 7'd0, 1'b0));
      end else begin
        fill--;
        typ = (fill != 0);
        expected_echo.push_back(echo_word(CH_BS[6:0], 1'b1, 1'b0, 1'b0, CMD_EMPTY, 7'd0, typ));
        expected_echo.push_back(echo_word(CH_SP[6:0], 1'b1, 1'b0, 1'b0, CMD_EMPTY, 7'd0, typ));
        expected_echo.push_back(echo_word(CH_BS[6:0], 1'b1, 1'b1, 1'b0, CMD_EMPTY, 7'd0, typ));
      end
    end else begin
      line_q[fill] = b[6:0];
      fill++;
      if (b == CH_CR || b == CH_LF) begin
        stop  = fill - 1;
        first = 0;
        while (first < stop && line_q[first] == CH_SP[6:0]) first++;
        span = stop - first;
        code = classify(first, span);
        fill = 0;
        expected_echo.push_back(echo_word(b[6:0], 1'b1, 1'b0, 1'b1, code, 7'(span), 1'b0));
        expected_echo.push_back(echo_word(CH_CR[6:0], 1'b1, 1'b0, 1'b1, code, 7'(span), 1'b0));
        expected_echo.push_back(echo_word(CH_LF[6:0], 1'b1, 1'b1, 1'b1, code, 7'(span), 1'b0));
      end else begin
        expected_echo.push_back(echo_word(b[6:0], 1'b1, 1'b1, 1'b0, CMD_EMPTY, 7'd0, 1'b1));
      end
    end
  endtask

  task automatic check_word();
    echo_word_t got;
    echo_word_t want;
    got.echo_char   = m_axis_tdata_i[6:0];
    got.code        = cmd_e'(m_axis_tdata_i[9:7]);
    got.length      = m_axis_tdata_i[16:10];
    got.last_of_run = m_axis_tlast_i;
    got.echo_valid  = m_axis_tuser_i[0];
    got.line_done   = m_axis_tuser_i[1];
    got.typing      = m_axis_tuser_i[2];
    if (expected_echo.size() == 0) begin
      fails++;
      if (fails <= 10)
        $display("%0t: echo word %06h with no byte pending", $realtime, m_axis_tdata_i);
    end else begin
      want = expected_echo.pop_front();
      if (got !== want || m_axis_tdata_i[23:17] !== 7'd0) begin
        fails++;
        if (fails <= 10)
          $display("%0t: echo mismatch, expected ch=%02h v=%0b last=%0b done=%0b code=%0d ",
                   $realtime, want.echo_char, want.echo_valid, want.last_of_run,
                   want.line_done, want.code,
                   "len=%0d typing=%0b, got ch=%02h v=%0b last=%0b done=%0b code=%0d ",
                   want.length, want.typing, got.echo_char, got.echo_valid,
                   got.last_of_run, got.line_done, got.code,
                   "len=%0d typing=%0b pad=%02h",
                   got.length, got.typing, m_axis_tdata_i[23:17]);
      end
    end
  endtask

  // Input words are predicted before output words are checked, so a word that
  // leaves in the same cycle always finds its expectation queued.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill = 0;
      fails = 0;
      expected_echo.delete();
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) take_byte(s_axis_tdata_i);
      if (m_axis_tvalid_i && m_axis_tready_i) check_word();
      pending_o <= expected_echo.size();
      fail_count_o <= fails;
    end
  end

endmodule
`default_nettype wire

[bench/tb.sv]
// Testbench top for the serial command line editor: clock, reset, byte stimulus and verdict.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sce_pkg::*;

  // Generous ceiling: a scan never runs past the end of the stored line, each run has
  // at most three words that may each sit out a stall, and well under a
  // thousand bytes are sent, so a correct run stays far below this.
  localparam int CYCLE_LIMIT = 400_000;

  logic        clk;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic [2:0]  m_axis_tuser_o;

  int fail_count;
  int pending;
  int cycle_count;
  int typed;      // bytes sent so far, dropped ones included
  bit calm;       // set for the closing stretch, where neither side idles

  serial_command_line_editor dut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  serial_command_line_editor_checker echo_check (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tlast_i  (m_axis_tlast_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake or a word that never arrives ends the run here.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("serial_command_line_editor verification failed");
      $finish;
    end
  end

  // Terminal side: ready most of the time, with random stall bursts until the
  // closing stretch. Each branch waits for a falling edge before tready is driven
  // again, so it changes at most once per step.
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      m_axis_tready_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  // Sends one byte. Called just after a falling edge; returns just after the
  // falling edge that follows the accepting rising edge, with tvalid still high
  // so that back-to-back bytes keep it up without a glitch.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    @(posedge clk);
    while (!s_axis_tready_o) @(posedge clk);
    typed++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++) send_byte(s[k]);
  endtask

  // Holds the input off until every predicted word has come out.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] printable();
    return 8'($urandom_range(CH_SP, CH_TIL));
  endfunction

  // A byte the editor drops: a high byte or a control code other than BS, LF, CR.
  function automatic logic [7:0] noise();
    logic [7:0] b;
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(8'h80, 8'hFF));
    b = 8'($urandom_range(0, 31));
    while (b == CH_BS || b == CH_LF || b == CH_CR) b = 8'($urandom_range(0, 31));
    return b;
  endfunction

  // One well-formed command line with random decoration: optional leading
  // spaces, a command word, a near miss or no word, a tail with typos that are erased
  // again, stray dropped bytes, and a CR or LF at the end.
  task automatic send_line();
    int    lead;
    int    kind;
    int    tail;
    string body;
    lead = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    kind = $urandom_range(0, 8);
    case (kind)
      0: body = "READ";
      1: body = "HELP";
      2: body = "CLEAR";
      3: body = "STATUS";
      4: begin
        case ($urandom_range(0, 3))
          0: body = "REA";
          1: body = "HEL";
          2: body = "CLEA";
          default: body = "STATU";
        endcase
      end
      5: begin
        case ($urandom_range(0, 3))
          0: body = "read";
          1: body = "help";
          2: body = "Clear";
          default: body = "status";
        endcase
      end
      8: body = ($urandom_range(0, 1) == 0) ? "HELPREAD" : "CLEARSTATUS";
      default: body = "";
    endcase
    // A backspace at the very start of a line hits an empty store.
    if ($urandom_range(0, 5) == 0) send_byte(($urandom_range(0, 1) == 0) ? CH_BS : CH_DEL);
    repeat (lead) send_byte(CH_SP);
    send_text(body);
    if (kind == 6) tail = $urandom_range(1, 8);
    else tail = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 4);
    repeat (tail) begin
      if ($urandom_range(0, 9) == 0) send_byte(noise());
      if ($urandom_range(0, 7) == 0) begin
        send_byte(printable());
        send_byte(($urandom_range(0, 1) == 0) ? CH_BS : CH_DEL);
      end
      send_byte(printable());
    end
    // Now and then a backspace erases the last character, eating into the command word itself when no tail was sent.
    if ($urandom_range(0, 9) == 0) send_byte(CH_DEL);
    send_byte(($urandom_range(0, 1) == 0) ? CH_CR : CH_LF);
  endtask

  // A line of n characters starting with a letter, then one closing byte.
  task automatic send_long(input int n, input logic [7:0] closer);
    send_byte(8'($urandom_range("A", "Z")));
    repeat (n - 1) send_byte(printable());
    send_byte(closer);
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'h00;
    calm            = 1'b0;
    typed           = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    // Opening checks: dropped bytes at both ends of the code space, backspace
    // on an empty line, a READ line after leading spaces with a DEL edit and a
    // trailing character, a line of only a space, an unknown command and an
    // empty line.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h1F);
    send_byte(CH_BS);
    send_text("  READ");
    send_byte(CH_DEL);
    send_text("Dx");
    send_byte(CH_CR);
    send_byte(CH_SP);
    send_byte(CH_LF);
    send_byte(CH_TIL);
    send_byte(CH_CR);
    send_byte(CH_LF);
    drain();

    // Longest line the store takes, reported with its full length, and then a
    // line that runs into the limit and is thrown away by its next byte.
    send_long(LINE_DEPTH - 2, CH_CR);
    case ($urandom_range(0, 2))
      0: send_long(LINE_DEPTH - 1, CH_BS);
      1: send_long(LINE_DEPTH - 1, CH_LF);
      default: send_long(LINE_DEPTH - 1, printable());
    endcase
    send_line();

    // Random lines, with stray noise between them and occasional full drains.
    while (typed < 300) begin
      if ($urandom_range(0, 4) == 0) send_byte(noise());
      send_line();
      if ($urandom_range(0, 19) == 0) drain();
    end

    // Closing stretch at full rate on both sides.
    calm = 1'b1;
    while (typed < 350) send_line();

    drain();
    repeat (150) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("serial_command_line_editor verification clean");
    end else begin
      $display("serial_command_line_editor verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
rtl/core/sce_pkg.sv
rtl/core/sce_ram.sv
rtl/core/sce_scan.sv
rtl/core/serial_command_line_editor.sv
bench/serial_command_line_editor_checker.sv
bench/tb.sv
